// ===== rtl/core/pdfem_pkg.sv =====
`default_nettype none
package pdfem_pkg;

	localparam logic [7:0]  CH_CR        = 8'h0D;
	localparam logic [7:0]  CH_LF        = 8'h0A;
	localparam logic [63:0] PAT_STARTXRE = 64'h7374617274787265;
	localparam logic [7:0]  PAT_F        = 8'h66;
	localparam logic [39:0] PAT_EOF      = 40'h2525454F46;
	localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;
	localparam logic [31:0] WINDOW_RESET = 32'd1048576;
	localparam logic [32:0] EOF_LEN      = 33'd5;

	// line ending length after a marker
	localparam logic [1:0] EOL_NONE = 2'd0;
	localparam logic [1:0] EOL_ONE  = 2'd1;
	localparam logic [1:0] EOL_TWO  = 2'd2;

	typedef struct packed {
		logic [31:0] pos;
		logic [31:0] end_pos;
		logic        prev_cr;
		logic        byte_eol;
		logic        byte_lf;
		logic        eof_hit;
		logic        xref_hit;
	} match_info_t;

	typedef struct packed {
		logic        found;
		logic [31:0] end_offset;
		logic        used_xref;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/pdfem_match.sv =====
`default_nettype none
module pdfem_match (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	output pdfem_pkg::match_info_t     info
);

	logic [63:0] recent_q;
	logic [31:0] pos_q;
	logic [63:0] recent_next;
	logic [32:0] pos_inc;

	assign recent_next = {recent_q[55:0], data_byte};
	assign pos_inc     = {1'b0, pos_q} + 33'd1;

	always_comb begin
		info.pos      = pos_q;
		info.end_pos  = pos_inc[32] ? pdfem_pkg::POS_MAX : pos_inc[31:0];
		info.prev_cr  = (recent_q[7:0] == pdfem_pkg::CH_CR);
		info.byte_eol = (data_byte == pdfem_pkg::CH_CR) || (data_byte == pdfem_pkg::CH_LF);
		info.byte_lf  = (data_byte == pdfem_pkg::CH_LF);
		info.eof_hit  = (recent_next[39:0] == pdfem_pkg::PAT_EOF);
		info.xref_hit = (recent_q == pdfem_pkg::PAT_STARTXRE) && (data_byte == pdfem_pkg::PAT_F);
	end

	// history and position restart with each region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			pos_q    <= '0;
		end else if (step) begin
			if (last_byte) begin
				recent_q <= '0;
				pos_q    <= '0;
			end else begin
				recent_q <= recent_next;
				pos_q    <= info.end_pos;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pdfem_track.sv =====
`default_nettype none
module pdfem_track (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step,
	input  wire logic                  last_byte,
	input  wire logic [31:0]           window_bytes,
	input  pdfem_pkg::match_info_t     info,
	output pdfem_pkg::result_t         result
);

	logic        xref_seen_q, xref_seen_n;
	logic [31:0] xref_end_q, xref_end_n;
	logic        fe_seen_q, fe_seen_n;
	logic [31:0] fe_end_q, fe_end_n;
	logic [1:0]  fe_adj_q, fe_adj_n;
	logic        le_seen_q, le_seen_n;
	logic [31:0] le_end_q, le_end_n;
	logic [1:0]  le_adj_q, le_adj_n;
	logic [32:0] win_lo, win_hi, end_ext;
	logic        in_window;
	logic [31:0] sel_end;
	logic [1:0]  sel_adj;
	logic [32:0] sum;

	function automatic logic [1:0] eol_update(
		input logic [1:0]      adj,
		input logic [31:0]     eof_end,
		input pdfem_pkg::match_info_t mi
	);
		logic [1:0] r;
		r = adj;
		if (mi.pos == eof_end) begin
			r = mi.byte_eol ? pdfem_pkg::EOL_ONE : pdfem_pkg::EOL_NONE;
		end else if ({1'b0, mi.pos} == ({1'b0, eof_end} + 33'd1) &&
				adj == pdfem_pkg::EOL_ONE && mi.prev_cr && mi.byte_lf) begin
			r = pdfem_pkg::EOL_TWO;
		end
		return r;
	endfunction

	assign end_ext   = {1'b0, info.end_pos};
	assign win_lo    = {1'b0, xref_end_q} + pdfem_pkg::EOF_LEN;
	assign win_hi    = {1'b0, xref_end_q} + {1'b0, window_bytes};
	assign in_window = (end_ext >= win_lo) && (end_ext <= win_hi);

	always_comb begin
		xref_seen_n = xref_seen_q;
		xref_end_n  = xref_end_q;
		fe_seen_n   = fe_seen_q;
		fe_end_n    = fe_end_q;
		fe_adj_n    = fe_seen_q ? eol_update(fe_adj_q, fe_end_q, info) : fe_adj_q;
		le_seen_n   = le_seen_q;
		le_end_n    = le_end_q;
		le_adj_n    = le_seen_q ? eol_update(le_adj_q, le_end_q, info) : le_adj_q;
		if (info.eof_hit) begin
			if (!fe_seen_q) begin
				fe_seen_n = 1'b1;
				fe_end_n  = info.end_pos;
				fe_adj_n  = pdfem_pkg::EOL_NONE;
			end
			if (xref_seen_q && in_window) begin
				le_seen_n = 1'b1;
				le_end_n  = info.end_pos;
				le_adj_n  = pdfem_pkg::EOL_NONE;
			end
		end
		if (info.xref_hit && !xref_seen_q) begin
			xref_seen_n = 1'b1;
			xref_end_n  = info.end_pos;
		end
	end

	// pick the end that applies, then add the line ending with saturation
	always_comb begin
		sel_end = xref_seen_n ? le_end_n : fe_end_n;
		sel_adj = xref_seen_n ? le_adj_n : fe_adj_n;
		sum     = {1'b0, sel_end} + {31'd0, sel_adj};
		result.found      = xref_seen_n ? le_seen_n : fe_seen_n;
		result.used_xref  = xref_seen_n && le_seen_n;
		result.end_offset = '0;
		if (result.found) begin
			result.end_offset = sum[32] ? pdfem_pkg::POS_MAX : sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xref_seen_q <= 1'b0;
			xref_end_q  <= '0;
			fe_seen_q   <= 1'b0;
			fe_end_q    <= '0;
			fe_adj_q    <= pdfem_pkg::EOL_NONE;
			le_seen_q   <= 1'b0;
			le_end_q    <= '0;
			le_adj_q    <= pdfem_pkg::EOL_NONE;
		end else if (step) begin
			if (last_byte) begin
				xref_seen_q <= 1'b0;
				xref_end_q  <= '0;
				fe_seen_q   <= 1'b0;
				fe_end_q    <= '0;
				fe_adj_q    <= pdfem_pkg::EOL_NONE;
				le_seen_q   <= 1'b0;
				le_end_q    <= '0;
				le_adj_q    <= pdfem_pkg::EOL_NONE;
			end else begin
				xref_seen_q <= xref_seen_n;
				xref_end_q  <= xref_end_n;
				fe_seen_q   <= fe_seen_n;
				fe_end_q    <= fe_end_n;
				fe_adj_q    <= fe_adj_n;
				le_seen_q   <= le_seen_n;
				le_end_q    <= le_end_n;
				le_adj_q    <= le_adj_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/pdf_end_marker_scanner_top.sv =====
// A region's last byte enters the input register; its result then loads the result register.
// Throughput: one byte per cycle if in_stall is low; one input register feeds the marker logic.
// in_stall rises only when a region end waits behind an unread result in the output register.
// Reset (arst_n low, asynchronous): pipeline and region state cleared, window_bytes = 1048576.
`default_nettype none
module pdf_end_marker_scanner_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input requests
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	// result requests
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found,
	output logic [31:0]      end_offset,
	output logic             used_xref,
	// window register
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data
);

	logic                   valid_s1;
	logic [7:0]             data_byte_s1;
	logic                   last_byte_s1;
	logic [31:0]            window_q;
	logic                   out_valid_q;
	pdfem_pkg::result_t     res_q;
	pdfem_pkg::result_t     res;
	pdfem_pkg::match_info_t info;
	logic                   out_free;
	logic                   adv_s1;
	logic                   load_out;

	// Output register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;
	// A byte in s1 moves on unless it ends a region and the output is occupied.
	assign adv_s1   = valid_s1 && (!last_byte_s1 || out_free);
	assign load_out = adv_s1 && last_byte_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= pdfem_pkg::WINDOW_RESET;
		end else if (cfg_wr_en) begin
			window_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1 <= data_byte;
			last_byte_s1 <= last_byte;
		end
	end

	// Pattern match on the byte history, then marker bookkeeping.
	pdfem_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (data_byte_s1),
		.last_byte (last_byte_s1),
		.info      (info)
	);

	pdfem_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv_s1),
		.last_byte    (last_byte_s1),
		.window_bytes (window_q),
		.info         (info),
		.result       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = res_q.found;
	assign end_offset = res_q.end_offset;
	assign used_xref  = res_q.used_xref;

	// A region end that leaves s1 must show up as a result next cycle.
	a_end_loads: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_byte_s1 && !in_stall |=> out_valid)
		else $error("region end did not produce a result");

	// Back-pressure only comes from a waiting region end.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (last_byte_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked region end");

	// Not found carries no offset and no mode flag.
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (end_offset == '0) && !used_xref)
		else $error("not-found result carries data");

	// xref mode only reports when an end was found.
	a_xref_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && used_xref |-> found)
		else $error("used_xref without found");

endmodule
`default_nettype wire
